@@ design/ptpp_pkg.sv @@
// Package for the polyline projection block: field widths, coordinate and
// heading types and the multiplier request layout. No dependencies.
package ptpp_pkg;

  localparam int CoordW = 31;
  localparam int HeadW = 16;
  localparam int DefMaxVertices = 1024;
  localparam int DefFractionBits = 16;
  localparam int InDataW = 144;
  localparam int OutDataW = 80;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [HeadW-1:0] head_t;

  typedef struct packed {
    logic start;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
  } mul_req_t;

endpackage

@@ design/ptpp_serial_mul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Depends on ptpp_pkg for the request layout.
module ptpp_serial_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptpp_pkg::mul_req_t    req,
  output logic                  done,
  output logic signed [65:0]    product
);

  logic signed [65:0] acc_r, acc_nxt;
  logic signed [65:0] mcand_r, mcand_nxt;
  logic [32:0] mplier_r, mplier_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0;
      mcand_nxt = 66'(req.mul_a);
      mplier_nxt = req.mul_b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        if (cnt_r == 6'd32) begin
          acc_nxt = acc_r - mcand_r;
        end else begin
          acc_nxt = acc_r + mcand_r;
        end
      end
      mcand_nxt = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign product = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= 6'd32) else $error("multiplier count overrun");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r) else $error("done while still working");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("multiplier did not start");
`endif

endmodule

@@ design/ptpp_serial_div.sv @@
// Restoring bit-serial divider producing one quotient bit per cycle.
// Requires num < den; no package dependency.
module ptpp_serial_div #(
  parameter int FractionBits = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       num,
  input  logic [63:0]       den,
  output logic              done,
  output logic [FractionBits:0] quot
);

  localparam int CntW = $clog2(FractionBits + 1);

  logic [64:0] rem_r, rem_nxt;
  logic [63:0] den_r;
  logic [FractionBits:0] q_r, q_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [64:0] shifted;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done = 1'b0;
    shifted = {rem_r[63:0], 1'b0};
    if (start) begin
      rem_nxt = {1'b0, num};
      q_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        q_nxt = {q_r[FractionBits-1:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[FractionBits-1:0], 1'b0};
      end
      cnt_nxt = cnt_r + CntW'(1);
      if (cnt_r == CntW'(FractionBits - 1)) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  assign quot = q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

`ifndef SYNTH
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r) else $error("divider done while idle");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r < CntW'(FractionBits)) else $error("divider count overrun");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start) |-> rem_r < {1'b0, den_r}) else $error("remainder too big");
`endif

endmodule

@@ design/point_to_polyline_projection.sv @@
// Top level of the point-to-polyline projector: sequencer, shared serial
// multiplier and serial divider. Depends on ptpp_pkg, ptpp_serial_mul, ptpp_serial_div.
//
// Usage: one vertex is sent per input request on in_*; the query point
// is taken from the first vertex of each trajectory, and in_tlast marks
// the last vertex. One result request leaves on out_* after each last
// vertex. Each segment runs through a sequencer that drives a bit-serial
// 33x33 multiplier (result registered) and a bit-serial divider. A vertex
// whose segment needs the divide takes eight products and the divide; a
// clamped segment skips the divide and the projection products, a
// zero-length one stops after its squared length, and a first vertex or
// one past the limit takes no product. A last vertex after at least one
// segment adds three products before the result is loaded.
// One vertex is in work at a time; in_tready is high only when idle.
// The result sits in an output register; while the receiver stalls the
// block still accepts the next vertex, and only waits when a new result
// is ready and the old one was not taken. Reset clears all control state
// and starts a new trajectory.
module point_to_polyline_projection #(
  parameter int MAX_VERTICES  = ptpp_pkg::DefMaxVertices,
  parameter int FRACTION_BITS = ptpp_pkg::DefFractionBits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // query_x, query_y, vertex_x, vertex_y, vertex_heading (low to high)
  input  logic [ptpp_pkg::InDataW-1:0]  in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // proj_x, proj_y, proj_heading, within_trajectory, too_few_vertices
  output logic [ptpp_pkg::OutDataW-1:0] out_tdata
);

  localparam int CntW = $clog2(MAX_VERTICES + 1);
  localparam int FW = FRACTION_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_OUT  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;

  // multiply steps
  localparam logic [3:0] M_ABX2 = 4'd0;
  localparam logic [3:0] M_ABY2 = 4'd1;
  localparam logic [3:0] M_DX   = 4'd2;
  localparam logic [3:0] M_DY   = 4'd3;
  localparam logic [3:0] M_PX   = 4'd4;
  localparam logic [3:0] M_PY   = 4'd5;
  localparam logic [3:0] M_QX2  = 4'd6;
  localparam logic [3:0] M_QY2  = 4'd7;
  localparam logic [3:0] M_OX   = 4'd8;
  localparam logic [3:0] M_OY   = 4'd9;
  localparam logic [3:0] M_OH   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic mul_go_r, mul_go_nxt;

  logic signed [31:0] prev_x_r, prev_y_r, q_x_r, q_y_r, v_x_r, v_y_r;
  logic [15:0] prev_h_r, v_h_r;
  logic last_r;
  logic [CntW-1:0] count_r;
  logic [63:0] best_d_r, len2_r, dist_r;
  logic signed [65:0] dot_r;
  logic [FW:0] best_f_r, f_r;
  logic best_beyond_r, beyond_r;
  logic [CntW-1:0] best_idx_r;
  logic signed [31:0] bs_x_r, bs_y_r, be_x_r, be_y_r;
  logic [15:0] bs_h_r, be_h_r;
  logic signed [31:0] px_r, py_r;
  logic [15:0] ph_r;
  logic out_valid_r;
  logic [ptpp_pkg::OutDataW-1:0] out_data_r;
  logic seg_done_r;

  ptpp_pkg::mul_req_t mreq;
  logic mul_done;
  logic signed [65:0] mul_p;
  logic div_start, div_done;
  logic [FW:0] div_q;

  logic signed [32:0] abx, aby, apx, apy;
  logic signed [32:0] ma, mb;
  logic signed [65:0] rounded;
  logic signed [65:0] dot_sum;
  logic signed [15:0] hd;

  assign abx = 33'(v_x_r) - 33'(prev_x_r);
  assign aby = 33'(v_y_r) - 33'(prev_y_r);
  assign apx = 33'(q_x_r) - 33'(prev_x_r);
  assign apy = 33'(q_y_r) - 33'(prev_y_r);
  assign hd = 16'(be_h_r - bs_h_r);
  assign rounded = (mul_p + (66'sd1 <<< (FW - 1))) >>> FW;
  assign dot_sum = dot_r + mul_p;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_r)
      M_ABX2: begin ma = abx; mb = abx; end
      M_ABY2: begin ma = aby; mb = aby; end
      M_DX:   begin ma = abx; mb = apx; end
      M_DY:   begin ma = aby; mb = apy; end
      M_PX:   begin ma = 33'($signed({1'b0, f_r})); mb = abx; end
      M_PY:   begin ma = 33'($signed({1'b0, f_r})); mb = aby; end
      M_QX2:  begin ma = 33'(q_x_r) - 33'(px_r); mb = 33'(q_x_r) - 33'(px_r); end
      M_QY2:  begin ma = 33'(q_y_r) - 33'(py_r); mb = 33'(q_y_r) - 33'(py_r); end
      M_OX:   begin ma = 33'($signed({1'b0, best_f_r})); mb = 33'(be_x_r) - 33'(bs_x_r); end
      M_OY:   begin ma = 33'($signed({1'b0, best_f_r})); mb = 33'(be_y_r) - 33'(bs_y_r); end
      M_OH:   begin ma = 33'($signed({1'b0, best_f_r})); mb = 33'(hd); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign mreq.start = mul_go_r;
  assign mreq.mul_a = ma;
  assign mreq.mul_b = mb;

  ptpp_serial_mul u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq), .done(mul_done), .product(mul_p)
  );

  ptpp_serial_div #(.FractionBits(FW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(dot_sum[63:0]),
    .den(len2_r), .done(div_done), .quot(div_q)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign div_start = (state_r == S_MUL) && mul_done && (step_r == M_DY) &&
                     !(dot_sum < 0) && !(66'(len2_r) < dot_sum) &&
                     !(dot_sum == 66'(len2_r));

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    mul_go_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          unique case (step_r)
            M_ABY2: begin
              if (len2_r + 64'(mul_p) == 64'd0) begin
                state_nxt = S_FIN;
              end else begin
                step_nxt = M_DX;
                mul_go_nxt = 1'b1;
              end
            end
            M_DY: begin
              if (div_start) begin
                state_nxt = S_DIV;
              end else begin
                step_nxt = M_QX2;
                mul_go_nxt = 1'b1;
              end
            end
            M_PY: begin step_nxt = M_QX2; mul_go_nxt = 1'b1; end
            M_QY2: state_nxt = S_CMP;
            M_OH: state_nxt = S_WAIT;
            default: begin step_nxt = step_r + 4'd1; mul_go_nxt = 1'b1; end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
          step_nxt = M_PX;
          mul_go_nxt = 1'b1;
        end
      end
      S_CMP: state_nxt = S_FIN;
      S_FIN: begin
        if (last_r && (seg_done_r || count_r >= CntW'(2))) begin
          state_nxt = S_MUL;
          step_nxt = M_OX;
          mul_go_nxt = 1'b1;
        end else if (last_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // start segment work when a vertex is accepted in idle and forms a segment
    if (state_r == S_IDLE && in_tvalid && count_r != '0 &&
        count_r < CntW'(MAX_VERTICES)) begin
      state_nxt = S_MUL;
      step_nxt = M_ABX2;
      mul_go_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= M_ABX2;
      mul_go_r <= 1'b0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      mul_go_r <= mul_go_nxt;
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE && in_tvalid && count_r == '0) begin
        count_r <= CntW'(1);
      end
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        count_r <= '0;
      end
      if (state_r == S_FIN && seg_done_r) begin
        count_r <= count_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_done_r <= 1'b0;
    end else if (state_r == S_IDLE && in_tvalid) begin
      seg_done_r <= (count_r != '0) && (count_r < CntW'(MAX_VERTICES));
    end else if (state_r == S_FIN) begin
      seg_done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      last_r <= in_tlast;
      if (count_r == '0) begin
        q_x_r <= 32'($signed(in_tdata[30:0]));
        q_y_r <= 32'($signed(in_tdata[61:31]));
        prev_x_r <= 32'($signed(in_tdata[92:62]));
        prev_y_r <= 32'($signed(in_tdata[123:93]));
        prev_h_r <= in_tdata[139:124];
        bs_x_r <= 32'($signed(in_tdata[92:62]));
        bs_y_r <= 32'($signed(in_tdata[123:93]));
        bs_h_r <= in_tdata[139:124];
        be_x_r <= 32'($signed(in_tdata[92:62]));
        be_y_r <= 32'($signed(in_tdata[123:93]));
        be_h_r <= in_tdata[139:124];
        best_d_r <= '1;
        best_f_r <= '0;
        best_beyond_r <= 1'b0;
        best_idx_r <= '0;
      end
      v_x_r <= 32'($signed(in_tdata[92:62]));
      v_y_r <= 32'($signed(in_tdata[123:93]));
      v_h_r <= in_tdata[139:124];
    end
    if (state_r == S_MUL && mul_done) begin
      unique case (step_r)
        M_ABX2: len2_r <= 64'(mul_p);
        M_ABY2: len2_r <= len2_r + 64'(mul_p);
        M_DX: dot_r <= mul_p;
        M_DY: begin
          dot_r <= dot_sum;
          if (dot_sum < 0) begin
            f_r <= '0;
            beyond_r <= 1'b0;
            px_r <= prev_x_r;
            py_r <= prev_y_r;
          end else if (!div_start) begin
            f_r <= (FW+1)'(1) << FW;
            beyond_r <= (66'(len2_r) < dot_sum);
            px_r <= v_x_r;
            py_r <= v_y_r;
          end
        end
        M_PX: px_r <= prev_x_r + 32'(rounded);
        M_PY: py_r <= prev_y_r + 32'(rounded);
        M_QX2: dist_r <= 64'(mul_p);
        M_QY2: dist_r <= dist_r + 64'(mul_p);
        M_OX: px_r <= bs_x_r + 32'(rounded);
        M_OY: py_r <= bs_y_r + 32'(rounded);
        M_OH: ph_r <= bs_h_r + 16'(rounded);
        default: ;
      endcase
    end
    if (state_r == S_DIV && div_done) begin
      f_r <= div_q;
      beyond_r <= 1'b0;
    end
    if (state_r == S_CMP && dist_r < best_d_r) begin
      best_d_r <= dist_r;
      best_f_r <= f_r;
      best_beyond_r <= beyond_r;
      best_idx_r <= count_r - CntW'(1);
      bs_x_r <= prev_x_r;
      bs_y_r <= prev_y_r;
      bs_h_r <= prev_h_r;
      be_x_r <= v_x_r;
      be_y_r <= v_y_r;
      be_h_r <= v_h_r;
    end
    if (state_r == S_FIN && seg_done_r) begin
      prev_x_r <= v_x_r;
      prev_y_r <= v_y_r;
      prev_h_r <= v_h_r;
    end
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      if (count_r < CntW'(2)) begin
        out_data_r <= {1'b1, 1'b0, bs_h_r, bs_y_r[30:0], bs_x_r[30:0]};
      end else begin
        out_data_r <= {1'b0,
                       !(best_beyond_r && best_idx_r == count_r - CntW'(2)),
                       ph_r, py_r[30:0], px_r[30:0]};
      end
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mul_go_r) else $error("ready while working");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MAX_VERTICES)) else $error("vertex count overrun");
`endif

endmodule

@@ bench/point_to_polyline_projection_tb.sv @@
// Testbench for point_to_polyline_projection: streams trajectories of vertices,
// predicts each projection result in a scoreboard class and checks the output
// stream. Depends on ptpp_pkg and the block itself.
module point_to_polyline_projection_tb;

  localparam int FracBits = ptpp_pkg::DefFractionBits;
  localparam int MaxVerts = 16;
  localparam longint CycleLimit = 3000000;
  localparam ptpp_pkg::coord_t CoordMax = 31'sh3FFFFFFF;
  localparam ptpp_pkg::coord_t CoordMin = 31'sh40000000;
  localparam longint Unit = 65536;

  typedef struct {
    ptpp_pkg::coord_t qx;
    ptpp_pkg::coord_t qy;
    ptpp_pkg::coord_t vx;
    ptpp_pkg::coord_t vy;
    ptpp_pkg::head_t  h;
    bit     last;
  } vertex_req_t;

  typedef struct {
    ptpp_pkg::coord_t px;
    ptpp_pkg::coord_t py;
    ptpp_pkg::head_t  ph;
    bit     on_path;
    bit     few;
  } projection_t;

  class projection_scoreboard;
    longint prev_x, prev_y, query_x, query_y;
    longint start_x, start_y, end_x, end_y;
    int unsigned prev_h, start_h, end_h;
    int unsigned count, best_seg;
    longint unsigned best_dist, best_frac;
    bit best_beyond;
    projection_t pending[$];
    int errors;
    int checked;

    function new();
      count = 0;
      best_dist = '1;
      errors = 0;
      checked = 0;
    endfunction

    function longint round_q(longint v);
      return (v + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    endfunction

    function longint unsigned frac_div(longint unsigned num, longint unsigned den);
      longint unsigned r, q;
      r = num;
      q = 0;
      if (num >= den) return 64'd1 << FracBits;
      for (int i = 0; i < FracBits; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
      end
      return q;
    endfunction

    function longint unsigned sq_dist(longint dx, longint dy);
      return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    function void note(vertex_req_t v);
      longint vx, vy, abx, aby, apx, apy, dot, px, py, f, hd;
      longint unsigned len2, fr, d;
      bit beyond;
      projection_t res;
      vx = v.vx;
      vy = v.vy;
      if (count == 0) begin
        query_x = v.qx;
        query_y = v.qy;
        best_dist = '1;
        best_frac = 0;
        best_beyond = 0;
        best_seg = 0;
        start_x = vx; start_y = vy; start_h = 32'(v.h);
        end_x = vx; end_y = vy; end_h = 32'(v.h);
        prev_x = vx; prev_y = vy; prev_h = 32'(v.h);
        count = 1;
      end else if (count < MaxVerts) begin
        abx = vx - prev_x;
        aby = vy - prev_y;
        apx = query_x - prev_x;
        apy = query_y - prev_y;
        len2 = sq_dist(abx, aby);
        if (len2 != 0) begin
          dot = abx * apx + aby * apy;
          beyond = 0;
          if (dot < 0) begin
            fr = 0;
            d = sq_dist(apx, apy);
          end else if ($unsigned(dot) > len2) begin
            fr = 64'd1 << FracBits;
            beyond = 1;
            d = sq_dist(query_x - vx, query_y - vy);
          end else begin
            fr = frac_div(dot, len2);
            px = prev_x + round_q(longint'(fr) * abx);
            py = prev_y + round_q(longint'(fr) * aby);
            d = sq_dist(query_x - px, query_y - py);
          end
          if (d < best_dist) begin
            best_dist = d;
            best_frac = fr;
            best_beyond = beyond;
            best_seg = count - 1;
            start_x = prev_x; start_y = prev_y; start_h = prev_h;
            end_x = vx; end_y = vy; end_h = 32'(v.h);
          end
        end
        prev_x = vx; prev_y = vy; prev_h = 32'(v.h);
        count++;
      end
      if (!v.last) return;
      if (count < 2) begin
        res.px = ptpp_pkg::coord_t'(start_x);
        res.py = ptpp_pkg::coord_t'(start_y);
        res.ph = ptpp_pkg::head_t'(start_h);
        res.on_path = 0;
        res.few = 1;
      end else begin
        f = best_frac;
        hd = (end_h - start_h) & 16'hFFFF;
        if (hd >= 32768) hd = hd - 65536;
        res.px = ptpp_pkg::coord_t'(start_x + round_q(f * (end_x - start_x)));
        res.py = ptpp_pkg::coord_t'(start_y + round_q(f * (end_y - start_y)));
        res.ph = ptpp_pkg::head_t'(longint'(start_h) + round_q(f * hd));
        res.on_path = !(best_beyond && best_seg == count - 2);
        res.few = 0;
      end
      pending = {pending, res};
      count = 0;
    endfunction

    task report(string field, longint got, longint want);
      errors++;
      $display("Mismatch in %s: got %0d, expected %0d", field, got, want);
    endtask

    task check(logic [ptpp_pkg::OutDataW-1:0] data);
      projection_t want;
      ptpp_pkg::coord_t gx, gy;
      checked++;
      if (pending.size() == 0) begin
        report("result without a request", 1, 0);
        return;
      end
      want = pending.pop_front();
      gx = data[30:0];
      gy = data[61:31];
      if (gx != want.px) report("proj_x", gx, want.px);
      if (gy != want.py) report("proj_y", gy, want.py);
      if (data[77:62] != want.ph) report("proj_heading", data[77:62], want.ph);
      if (data[78] != want.on_path) report("within_trajectory", data[78], want.on_path);
      if (data[79] != want.few) report("too_few_vertices", data[79], want.few);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [ptpp_pkg::InDataW-1:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [ptpp_pkg::OutDataW-1:0] out_tdata;

  projection_scoreboard sb = new();
  longint cycles = 0;
  int burst_left = 0;
  int sent = 0;
  int trajectories = 0;

  point_to_polyline_projection #(.MAX_VERTICES(MaxVerts)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver stalls on its own pattern, stepping through four modes as the cycle count grows.
  always @(negedge clk) begin
    case ((cycles >> 9) % 4)
      0: begin
        out_tready = 1;
      end
      1: begin
        out_tready = $urandom_range(0, 1);
      end
      2: begin
        out_tready = ($urandom_range(0, 9) == 0);
      end
      default: begin
        out_tready = cycles[0];
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
  end

  task automatic send(vertex_req_t v);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid = 0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid = 1;
    in_tdata = {4'b0, v.h, v.vy, v.vx, v.qy, v.qx};
    in_tlast = v.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note(v);
    sent++;
    if (v.last) trajectories++;
    burst_left--;
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic send_v(longint qx, longint qy, longint vx, longint vy, int h, bit last);
    vertex_req_t v;
    v.qx = ptpp_pkg::coord_t'(qx);
    v.qy = ptpp_pkg::coord_t'(qy);
    v.vx = ptpp_pkg::coord_t'(vx);
    v.vy = ptpp_pkg::coord_t'(vy);
    v.h = ptpp_pkg::head_t'(h);
    v.last = last;
    send(v);
  endtask

  function automatic ptpp_pkg::coord_t rand_coord();
    logic [31:0] r;
    r = $urandom;
    return r[30:0];
  endfunction

  function automatic ptpp_pkg::coord_t near(ptpp_pkg::coord_t c, int span);
    return ptpp_pkg::coord_t'(c + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_traj();
    int n;
    bit wide;
    ptpp_pkg::coord_t cx, cy, qx, qy, vx, vy;
    ptpp_pkg::head_t h;
    n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
    wide = ($urandom_range(0, 3) == 0);
    cx = ptpp_pkg::coord_t'($signed($urandom_range(0, 1 << 30)) - (1 << 29));
    cy = ptpp_pkg::coord_t'($signed($urandom_range(0, 1 << 30)) - (1 << 29));
    qx = wide ? rand_coord() : near(cx, 1 << 21);
    qy = wide ? rand_coord() : near(cy, 1 << 21);
    h = ptpp_pkg::head_t'($urandom);
    vx = cx;
    vy = cy;
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        vx = rand_coord();
        vy = rand_coord();
        h = ptpp_pkg::head_t'($urandom);
      end else if ($urandom_range(0, 7) != 0) begin
        vx = near(vx, 1 << 20);
        vy = near(vy, 1 << 20);
        h = ptpp_pkg::head_t'(h + $urandom_range(0, 16000) - 8000);
      end
      send_v(qx, qy, vx, vy, h, i == n - 1);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Single vertex at the coordinate extremes.
    send_v(CoordMin, CoordMax, CoordMax, CoordMin, 65535, 1);
    // Query behind the start, then beyond the end of the only segment.
    send_v(-5 * Unit, 0, 0, 0, 100, 0);
    send_v(0, 0, 10 * Unit, 0, 200, 1);
    send_v(15 * Unit, 3 * Unit, 0, 0, 65000, 0);
    send_v(0, 0, 10 * Unit, 0, 500, 1);
    // All segments of zero length.
    send_v(7 * Unit, 7 * Unit, 3 * Unit, -2 * Unit, 1234, 0);
    send_v(0, 0, 3 * Unit, -2 * Unit, 999, 0);
    send_v(0, 0, 3 * Unit, -2 * Unit, 42, 1);
    // Exactly opposite headings, query near the middle.
    send_v(5 * Unit + 7, Unit, 0, 0, 0, 0);
    send_v(0, 0, 10 * Unit, 0, 32768, 1);
    // Segment spanning the whole coordinate range.
    send_v(CoordMax, CoordMin, CoordMin, CoordMin, 16'h0001, 0);
    send_v(0, 0, CoordMax, CoordMax, 16'hFFFE, 1);
    // Equal distances to two segments: the earlier one is kept.
    send_v(10 * Unit, 5 * Unit, 0, 0, 10, 0);
    send_v(0, 0, 10 * Unit, 0, 20, 0);
    send_v(0, 0, 20 * Unit, 0, 30, 1);
    // Beyond the end of the first of two segments still counts as within.
    send_v(12 * Unit, 0, 0, 0, 0, 0);
    send_v(0, 0, 10 * Unit, 0, 8192, 0);
    send_v(0, 0, 10 * Unit, -10 * Unit, 16384, 1);

    // Trajectory longer than the vertex limit; later vertices only step back and forth in y.
    for (int i = 0; i < MaxVerts + 6; i++) begin
      send_v(3 * Unit + 11, 2 * Unit, (i < 8 ? i : 8) * Unit, (i % 2) * Unit,
             i * 97, i == MaxVerts + 5);
    end

    while (sent < 400) random_traj();

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Sent %0d vertex requests in %0d trajectories; checked %0d results.",
             sent, trajectories, sb.checked);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
